FILE: src/bal_pkg.sv
// shared types and constants for the binary artmap learner
package bal_pkg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_COUNT,
        S_SEARCH,
        S_CHECK,
        S_LABCMP,
        S_DIV,
        S_TRACK,
        S_CREATE,
        S_PLAB,
        S_PRED,
        S_EMPTY
    } t_state;

    localparam logic       OP_TRAIN   = 1'b0;
    localparam logic       OP_PREDICT = 1'b1;

    localparam logic [2:0] MODE_MT_PLUS  = 3'd0;
    localparam logic [2:0] MODE_MT_MINUS = 3'd1;
    localparam logic [2:0] MODE_MT_ZERO  = 3'd2;
    localparam logic [2:0] MODE_MT_ONE   = 3'd3;
    localparam logic [2:0] MODE_MT_TILDE = 3'd4;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    localparam logic [2:0] REG_VIGILANCE     = 3'd0;
    localparam logic [2:0] REG_CHOICE_ALPHA  = 3'd1;
    localparam logic [2:0] REG_TRACKING_EPS  = 3'd2;
    localparam logic [2:0] REG_MATCH_MODE    = 3'd3;
    localparam logic [2:0] REG_FEATURE_COUNT = 3'd4;

    localparam logic [16:0] RST_VIGILANCE     = 17'd49152;
    localparam logic [15:0] RST_CHOICE_ALPHA  = 16'd1;
    localparam logic [16:0] RST_TRACKING_EPS  = 17'd66;
    localparam logic [2:0]  RST_MATCH_MODE    = 3'd0;
    localparam logic [5:0]  RST_FEATURE_COUNT = 6'd32;

    localparam int          AV_W    = 19;
    localparam logic [18:0] ONE_Q16 = 19'd65536;

endpackage

FILE: src/binary_artmap_learner_top.sv
// binary fuzzy artmap learner: count, choice search, vigilance and match tracking
// o_busy high while working: predict runs the count and search scans, then reads the label;
// train runs both scans, then vigilance, rescanning per reject; a label conflict runs a q16
// divide (not mt1, mt~), then rescans or creates; a match updates; empty store skips scans
// result strobe in the cycle busy drops; receiver cannot stall, one transaction at a time
// synchronous active-low reset clears cluster count, registers and control; memories keep data
module binary_artmap_learner_top #(
    parameter int MAX_CLUSTERS = 64,
    parameter int MAX_FEATURES = 32,
    parameter int LABEL_BITS   = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic        i_operation,
    input  logic [63:0] i_sample_bits,
    input  logic [7:0]  i_class_label,
    output logic        o_valid,
    output logic [5:0]  o_cluster_index,
    output logic [7:0]  o_mapped_label,
    output logic        o_created,
    output logic [1:0]  o_status,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bal_pkg::*;

    localparam int CW  = $clog2(MAX_CLUSTERS);
    localparam int NW  = CW + 1;
    localparam int SW  = 2 * MAX_FEATURES;
    localparam int PW  = $clog2(SW + 1);
    localparam int DW  = ((PW + 8) > 16 ? PW + 8 : 16) + 1;
    localparam int QW  = PW + 16;
    localparam int DCW = $clog2(QW + 1);
    localparam int MW  = PW + DW;
    localparam int CMW = 1 + 2 * PW;

    function automatic logic [PW-1:0] popcnt(input logic [SW-1:0] v);
        logic [PW-1:0] s;
        s = '0;
        for (int j = 0; j < SW; j++) s = s + PW'(v[j]);
        return s;
    endfunction

    // configuration
    logic [16:0] r_vig;
    logic [15:0] r_alpha;
    logic [16:0] r_eps;
    logic [2:0]  r_cmode;
    logic [5:0]  r_feat;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vig   <= RST_VIGILANCE;
            r_alpha <= RST_CHOICE_ALPHA;
            r_eps   <= RST_TRACKING_EPS;
            r_cmode <= RST_MATCH_MODE;
            r_feat  <= RST_FEATURE_COUNT;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                REG_VIGILANCE:     r_vig   <= pwdata[16:0];
                REG_CHOICE_ALPHA:  r_alpha <= pwdata[15:0];
                REG_TRACKING_EPS:  r_eps   <= pwdata[16:0];
                REG_MATCH_MODE:    r_cmode <= pwdata[2:0];
                REG_FEATURE_COUNT: r_feat  <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_VIGILANCE:     prdata = 32'(r_vig);
            REG_CHOICE_ALPHA:  prdata = 32'(r_alpha);
            REG_TRACKING_EPS:  prdata = 32'(r_eps);
            REG_MATCH_MODE:    prdata = 32'(r_cmode);
            REG_FEATURE_COUNT: prdata = 32'(r_feat);
            default:           prdata = '0;
        endcase
    end

    // effective feature count, sample mask, prefilter threshold and match mode
    logic [5:0]  f_eff;
    logic [63:0] mask;
    logic [22:0] rho_prod;
    logic [2:0]  mode_eff;

    always_comb begin
        if (r_feat == 6'd0) f_eff = 6'd1;
        else if (32'(r_feat) > MAX_FEATURES) f_eff = 6'(MAX_FEATURES);
        else f_eff = r_feat;
        for (int j = 0; j < 64; j++) mask[j] = (7'(j) < {f_eff, 1'b0});
        rho_prod = 23'(r_vig) * 23'(f_eff);
        mode_eff = (r_cmode > MODE_MT_TILDE) ? MODE_MT_PLUS : r_cmode;
    end

    // memories
    logic [SW-1:0]         r_wmem [MAX_CLUSTERS];
    logic [LABEL_BITS-1:0] r_lmem [MAX_CLUSTERS];
    logic [CMW-1:0]        r_cmem [MAX_CLUSTERS];
    logic [SW-1:0]         r_wrd;
    logic [LABEL_BITS-1:0] r_lrd;
    logic [CMW-1:0]        r_crd;

    logic                  w_we, l_we, c_we;
    logic [CW-1:0]         w_waddr, l_waddr, c_waddr, wl_raddr, c_raddr;
    logic [SW-1:0]         w_wdata;
    logic [LABEL_BITS-1:0] l_wdata;
    logic [CMW-1:0]        c_wdata;

    always_ff @(posedge i_clk) begin
        if (w_we) r_wmem[w_waddr] <= w_wdata;
        r_wrd <= r_wmem[wl_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (l_we) r_lmem[l_waddr] <= l_wdata;
        r_lrd <= r_lmem[wl_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (c_we) r_cmem[c_waddr] <= c_wdata;
        r_crd <= r_cmem[c_raddr];
    end

    // datapath and control registers
    t_state                r_state, n_state;
    logic [NW-1:0]         r_count, n_count, r_n, n_n, r_idx, n_idx;
    logic                  r_pend, n_pend;
    logic [CW-1:0]         r_pidx, n_pidx;
    logic [SW-1:0]         r_x, n_x, r_mask, n_mask;
    logic [5:0]            r_f, n_f;
    logic [LABEL_BITS-1:0] r_lab, n_lab;
    logic                  r_op, n_op;
    logic [2:0]            r_mode, n_mode;
    logic [6:0]            r_rho, n_rho;
    logic [AV_W-1:0]       r_av, n_av;
    logic [CW-1:0]         r_best, n_best;
    logic [PW-1:0]         r_bov, n_bov, r_bwc, n_bwc;
    logic [DW-1:0]         r_bden, n_bden;
    logic                  r_bvalid, n_bvalid;
    logic [QW-1:0]         r_quo, n_quo;
    logic [6:0]            r_rem, n_rem;
    logic [DCW-1:0]        r_dcnt, n_dcnt;
    logic                  r_valid, n_valid;
    logic [5:0]            r_oidx, n_oidx;
    logic [7:0]            r_olab, n_olab;
    logic                  r_ocre, n_ocre;
    logic [1:0]            r_ostat, n_ostat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n      <= n_n;
        r_idx    <= n_idx;
        r_pidx   <= n_pidx;
        r_x      <= n_x;
        r_mask   <= n_mask;
        r_f      <= n_f;
        r_lab    <= n_lab;
        r_op     <= n_op;
        r_mode   <= n_mode;
        r_rho    <= n_rho;
        r_av     <= n_av;
        r_best   <= n_best;
        r_bov    <= n_bov;
        r_bwc    <= n_bwc;
        r_bden   <= n_bden;
        r_bvalid <= n_bvalid;
        r_quo    <= n_quo;
        r_rem    <= n_rem;
        r_dcnt   <= n_dcnt;
        r_oidx   <= n_oidx;
        r_olab   <= n_olab;
        r_ocre   <= n_ocre;
        r_ostat  <= n_ostat;
    end

    logic            issue, scan_done, ge, pre, excl, to_create;
    logic [SW-1:0]   wm;
    logic [PW-1:0]   k_ov, k_wc, c_ov, c_wc;
    logic            c_live;
    logic [DW-1:0]   k_den, c_den;
    logic [MW-1:0]   lhs, rhs;
    logic [31:0]     vig_l, vig_r, quo32, trk;
    logic [6:0]      dsh;

    always_comb begin
        issue     = (r_idx < r_n);
        scan_done = !issue && !r_pend;
        ge        = (r_mode == MODE_MT_PLUS) || (r_mode == MODE_MT_MINUS) ||
                    (r_mode == MODE_MT_ONE);

        wm    = r_wrd & r_mask;
        k_ov  = popcnt(r_x & wm);
        k_wc  = popcnt(wm);
        k_den = DW'(r_alpha) + (DW'(k_wc) << 8);
        if (r_mode == MODE_MT_MINUS) pre = 1'b1;
        else if (ge) pre = (32'(k_ov) >= 32'(r_rho));
        else pre = (32'(k_ov) > 32'(r_rho));

        c_live = r_crd[2*PW];
        c_ov   = r_crd[2*PW-1:PW];
        c_wc   = r_crd[PW-1:0];
        c_den  = DW'(r_alpha) + (DW'(c_wc) << 8);
        lhs    = MW'(c_ov) * MW'(r_bden);
        rhs    = MW'(r_bov) * MW'(c_den);

        // overlap/F against active vigilance, both scaled by F
        vig_l = 32'({r_bov, 16'h0000});
        vig_r = 32'(25'(r_av) * 25'(r_f));

        dsh   = {r_rem[5:0], r_quo[QW-1]};
        quo32 = 32'(r_quo);
        case (r_mode)
            MODE_MT_PLUS:  trk = quo32 + 32'(r_eps);
            MODE_MT_MINUS: trk = (quo32 > 32'(r_eps)) ? quo32 - 32'(r_eps) : 32'd0;
            MODE_MT_ZERO:  trk = quo32 + 32'(r_rem != 7'd0);
            default:       trk = 32'(r_av);
        endcase

        n_state  = r_state;
        n_count  = r_count;
        n_n      = r_n;
        n_idx    = r_idx;
        n_pend   = 1'b0;
        n_pidx   = r_idx[CW-1:0];
        n_x      = r_x;
        n_mask   = r_mask;
        n_f      = r_f;
        n_lab    = r_lab;
        n_op     = r_op;
        n_mode   = r_mode;
        n_rho    = r_rho;
        n_av     = r_av;
        n_best   = r_best;
        n_bov    = r_bov;
        n_bwc    = r_bwc;
        n_bden   = r_bden;
        n_bvalid = r_bvalid;
        n_quo    = r_quo;
        n_rem    = r_rem;
        n_dcnt   = r_dcnt;
        n_valid  = 1'b0;
        n_oidx   = r_oidx;
        n_olab   = r_olab;
        n_ocre   = r_ocre;
        n_ostat  = r_ostat;

        w_we     = 1'b0;
        w_waddr  = r_best;
        w_wdata  = r_x & r_wrd;
        l_we     = 1'b0;
        l_waddr  = r_count[CW-1:0];
        l_wdata  = r_lab;
        c_we     = 1'b0;
        c_waddr  = r_pidx;
        c_wdata  = {1'b0, r_bov, r_bwc};
        wl_raddr = r_idx[CW-1:0];
        c_raddr  = r_idx[CW-1:0];
        excl      = 1'b0;
        to_create = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_x    = i_sample_bits[SW-1:0] & mask[SW-1:0];
                    n_mask = mask[SW-1:0];
                    n_f    = f_eff;
                    n_lab  = LABEL_BITS'(i_class_label);
                    n_op   = i_operation;
                    n_mode = mode_eff;
                    n_rho  = 7'(rho_prod >> 16);
                    n_n    = r_count;
                    n_idx  = '0;
                    if (i_operation == OP_TRAIN) n_av = AV_W'(r_vig);
                    if (r_count == '0) begin
                        n_state = (i_operation == OP_PREDICT) ? S_EMPTY : S_CREATE;
                    end else begin
                        n_state = S_COUNT;
                    end
                end
            end
            S_COUNT: begin
                if (issue) begin
                    n_idx  = r_idx + 1'b1;
                    n_pend = 1'b1;
                end
                if (r_pend) begin
                    c_we    = 1'b1;
                    c_wdata = {(k_den != '0) && (r_op == OP_PREDICT || pre), k_ov, k_wc};
                end
                if (scan_done) begin
                    n_idx    = '0;
                    n_bvalid = 1'b0;
                    n_best   = '0;
                    n_state  = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (issue) begin
                    n_idx  = r_idx + 1'b1;
                    n_pend = 1'b1;
                end
                // strict compare keeps the lowest index on a tie
                if (r_pend && c_live && (!r_bvalid || lhs > rhs)) begin
                    n_bvalid = 1'b1;
                    n_best   = r_pidx;
                    n_bov    = c_ov;
                    n_bwc    = c_wc;
                    n_bden   = c_den;
                end
                if (scan_done) begin
                    if (r_op == OP_PREDICT) n_state = S_PLAB;
                    else if (r_bvalid) n_state = S_CHECK;
                    else n_state = S_CREATE;
                end
            end
            S_CHECK: begin
                wl_raddr = r_best;
                if (ge ? (vig_l >= vig_r) : (vig_l > vig_r)) n_state = S_LABCMP;
                else excl = 1'b1;
            end
            S_LABCMP: begin
                if (r_lrd == r_lab) begin
                    w_we    = 1'b1;
                    n_valid = 1'b1;
                    n_oidx  = 6'(r_best);
                    n_olab  = 8'(r_lab);
                    n_ocre  = 1'b0;
                    n_ostat = STAT_OK;
                    n_state = S_IDLE;
                end else if (r_mode == MODE_MT_ONE) begin
                    to_create = 1'b1;
                end else if (r_mode == MODE_MT_TILDE) begin
                    if (r_av > ONE_Q16) to_create = 1'b1;
                    else excl = 1'b1;
                end else begin
                    n_quo   = {r_bov, 16'h0000};
                    n_rem   = '0;
                    n_dcnt  = DCW'(QW);
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                // one quotient bit per cycle of overlap*65536 / F
                if (dsh >= {1'b0, r_f}) begin
                    n_rem = dsh - {1'b0, r_f};
                    n_quo = {r_quo[QW-2:0], 1'b1};
                end else begin
                    n_rem = dsh;
                    n_quo = {r_quo[QW-2:0], 1'b0};
                end
                n_dcnt = r_dcnt - 1'b1;
                if (r_dcnt == DCW'(1)) n_state = S_TRACK;
            end
            S_TRACK: begin
                n_av = AV_W'(trk);
                if (AV_W'(trk) > ONE_Q16) to_create = 1'b1;
                else excl = 1'b1;
            end
            S_CREATE: begin
                n_valid = 1'b1;
                n_olab  = 8'(r_lab);
                n_state = S_IDLE;
                if (32'(r_count) >= MAX_CLUSTERS) begin
                    n_oidx  = '0;
                    n_ocre  = 1'b0;
                    n_ostat = STAT_FULL;
                end else begin
                    w_we    = 1'b1;
                    w_waddr = r_count[CW-1:0];
                    w_wdata = r_x;
                    l_we    = 1'b1;
                    n_oidx  = 6'(r_count);
                    n_ocre  = 1'b1;
                    n_ostat = STAT_OK;
                    n_count = r_count + 1'b1;
                end
            end
            S_PLAB: begin
                wl_raddr = r_best;
                n_state  = S_PRED;
            end
            S_PRED: begin
                n_valid = 1'b1;
                n_oidx  = 6'(r_best);
                n_olab  = 8'(r_lrd);
                n_ocre  = 1'b0;
                n_ostat = STAT_OK;
                n_state = S_IDLE;
            end
            S_EMPTY: begin
                n_valid = 1'b1;
                n_oidx  = '0;
                n_olab  = '0;
                n_ocre  = 1'b0;
                n_ostat = STAT_EMPTY;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase

        // drop the current best from the search and scan again
        if (excl) begin
            c_we     = 1'b1;
            c_waddr  = r_best;
            c_wdata  = {1'b0, r_bov, r_bwc};
            n_idx    = '0;
            n_bvalid = 1'b0;
            n_best   = '0;
            n_state  = S_SEARCH;
        end
        if (to_create) n_state = S_CREATE;
    end

    assign o_busy          = (r_state != S_IDLE);
    assign o_valid         = r_valid;
    assign o_cluster_index = r_oidx;
    assign o_mapped_label  = r_olab;
    assign o_created       = r_ocre;
    assign o_status        = r_ostat;

endmodule

FILE: src/bal_checker.sv
// port-level checks for the binary artmap learner, bound to the top level
module bal_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_start,
    input logic       o_busy,
    input logic       o_valid,
    input logic [5:0] o_cluster_index,
    input logic       o_created,
    input logic [1:0] o_status
);
    import bal_pkg::*;

    // every accepted transaction raises busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted transaction did not raise busy");

    // busy drops exactly when the result strobe shows
    a_fall_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_busy) |-> o_valid)
        else $error("busy fell without a result");

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_busy)
        else $error("result shown while busy");

    a_created_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_created) |-> (o_status == STAT_OK))
        else $error("created cluster with error status");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == STAT_EMPTY) |-> (o_cluster_index == 6'd0 && !o_created))
        else $error("empty predict with nonzero fields");

endmodule

bind binary_artmap_learner_top bal_checker u_bal_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_start         (i_start),
    .o_busy          (o_busy),
    .o_valid         (o_valid),
    .o_cluster_index (o_cluster_index),
    .o_created       (o_created),
    .o_status        (o_status)
);
